[src/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg - shared types and codes of the session table
// Holds the table entry layout, the operation codes and the register indexes.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Operation codes carried in the func field.
  localparam logic [2:0] FN_CREATE      = 3'd0;
  localparam logic [2:0] FN_LOOKUP      = 3'd1;
  localparam logic [2:0] FN_DESTROY     = 3'd2;
  localparam logic [2:0] FN_SWEEP       = 3'd3;
  localparam logic [2:0] FN_DESTROY_ALL = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SESSION_TTL  = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT = 1'b1;

  // Stored fields of one session, without its valid flag.
  typedef struct packed {
    logic [255:0] key;
    logic [63:0]  user;
    logic [63:0]  tag;
    logic [39:0]  created;
    logic [39:0]  used_at;
  } pay_t;

  // One table entry as it moves along the chain.
  typedef struct packed {
    logic valid;
    pay_t pay;
  } entry_t;

endpackage

[src/stl_cell.sv]
// ----------------------------------------------------------------------------
// stl_cell - one slot of the session table
// Holds one entry and loads its neighbor's entry on every shift cycle.
// ----------------------------------------------------------------------------
module stl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  stl_pkg::entry_t d,
  output stl_pkg::entry_t q
);

  logic          valid_r;
  stl_pkg::pay_t pay_r;

  // The valid flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
    end
  end

  // Stored fields carry no reset; they only matter while valid.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pay_r <= d.pay;
    end
  end

  assign q.valid = valid_r;
  assign q.pay   = pay_r;

endmodule

[src/session_table_lru_ttl_core.sv]
// ----------------------------------------------------------------------------
// session_table_lru_ttl_core - session table with LRU eviction and timeouts
// The entries sit in a ring of cells that, while an item is in work, rotates one
// slot per cycle past a head unit that matches, ages, evicts and rewrites them.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | func, key words, user, tag, now
//   out_    | output    | out_valid / out_ready | status, slot, entry, occupied
//   cfg_    | input     | cfg_we                | session_ttl, idle_timeout
//
// Create makes two rotations of the ring (one to find the free or oldest
// slot, one to write it); every other operation makes one rotation.
// Reset is synchronous and clears all valid flags and the occupied count.
// A new item is taken while a finished result still waits in the output
// register; the block holds before loading the next result until it is taken.
// ----------------------------------------------------------------------------
module session_table_lru_ttl_core #(
  parameter int SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [2:0]   in_func,
  input  logic [63:0]  in_key_w0,
  input  logic [63:0]  in_key_w1,
  input  logic [63:0]  in_key_w2,
  input  logic [63:0]  in_key_w3,
  input  logic [63:0]  in_user_id,
  input  logic [63:0]  in_session_tag,
  input  logic [39:0]  in_now,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_status,
  output logic [5:0]   out_slot,
  output logic [63:0]  out_user_id,
  output logic [63:0]  out_session_tag,
  output logic [39:0]  out_created,
  output logic [39:0]  out_last_used,
  output logic [6:0]   out_occupied,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIVE_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_PASS1, S_PASS2, S_FINISH} state_t;

  state_t              st_r, st_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    tgt_r, tgt_nxt;
  logic [IDX_W-1:0]    lru_idx_r, lru_idx_nxt;
  logic [39:0]         lru_min_r, lru_min_nxt;
  logic                found_r, found_nxt;
  logic [LIVE_W-1:0]   live_r, live_nxt;
  logic [31:0]         ttl_r, idle_r;

  logic [2:0]          func_r;
  logic [255:0]        key_r;
  logic [63:0]         user_r, tag_r;
  logic [39:0]         now_r;

  logic                res_status_r, res_status_nxt;
  logic [5:0]          res_slot_r, res_slot_nxt;
  stl_pkg::pay_t       res_pay_r, res_pay_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r;
  logic [5:0]          out_slot_r;
  stl_pkg::pay_t       out_pay_r;
  logic [6:0]          out_occ_r;

  stl_pkg::entry_t     cell_q [SLOTS];
  stl_pkg::entry_t     head, head_mod;
  logic                shift_en;
  logic                key_hit, ttl_exp, idle_exp, accept, load_out;
  logic [39:0]         el_created, el_used;

  // Ring of cells: slot k sits in cell 0 at step k of a rotation.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    stl_pkg::entry_t d;
    if (i == SLOTS - 1) begin : g_tail
      assign d = head_mod;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    stl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (d),
      .q        (cell_q[i])
    );
  end

  // Compare and age the entry at the head of the ring.
  assign head       = cell_q[0];
  assign key_hit    = head.valid && (head.pay.key == key_r);
  assign el_created = (now_r >= head.pay.created) ? now_r - head.pay.created : 40'd0;
  assign el_used    = (now_r >= head.pay.used_at) ? now_r - head.pay.used_at : 40'd0;
  assign ttl_exp    = el_created > {8'd0, ttl_r};
  assign idle_exp   = el_used > {8'd0, idle_r};

  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Head unit and sequencer.
  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    tgt_nxt        = tgt_r;
    lru_idx_nxt    = lru_idx_r;
    lru_min_nxt    = lru_min_r;
    found_nxt      = found_r;
    live_nxt       = live_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_pay_nxt    = res_pay_r;
    head_mod       = head;
    shift_en       = 1'b0;
    load_out       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt         = S_PASS1;
          cnt_nxt        = '0;
          found_nxt      = 1'b0;
          res_status_nxt = (in_func == stl_pkg::FN_LOOKUP);
          res_slot_nxt   = '0;
          res_pay_nxt    = '0;
        end
      end
      S_PASS1: begin
        shift_en = 1'b1;
        cnt_nxt  = cnt_r + IDX_W'(1);
        unique case (func_r)
          stl_pkg::FN_CREATE: begin
            if (!found_r && !head.valid) begin
              found_nxt = 1'b1;
              tgt_nxt   = cnt_r;
            end
            if (cnt_r == '0 || head.pay.used_at < lru_min_r) begin
              lru_min_nxt = head.pay.used_at;
              lru_idx_nxt = cnt_r;
            end
          end
          stl_pkg::FN_LOOKUP: begin
            if (key_hit && !found_r) begin
              found_nxt = 1'b1;
              if (ttl_exp || idle_exp) begin
                head_mod.valid = 1'b0;
                live_nxt       = live_r - LIVE_W'(1);
              end else begin
                head_mod.pay.used_at = now_r;
                res_status_nxt       = 1'b0;
                res_slot_nxt         = 6'(cnt_r);
                res_pay_nxt          = head.pay;
                res_pay_nxt.used_at  = now_r;
              end
            end
          end
          stl_pkg::FN_DESTROY: begin
            if (key_hit && !found_r) begin
              found_nxt      = 1'b1;
              head_mod.valid = 1'b0;
              live_nxt       = live_r - LIVE_W'(1);
            end
          end
          stl_pkg::FN_SWEEP: begin
            if (head.valid && ttl_exp) begin
              head_mod.valid = 1'b0;
              live_nxt       = live_r - LIVE_W'(1);
            end
          end
          stl_pkg::FN_DESTROY_ALL: begin
            head_mod.valid = 1'b0;
            live_nxt       = '0;
          end
          default: begin
          end
        endcase
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          if (func_r == stl_pkg::FN_CREATE) begin
            st_nxt = S_PASS2;
            if (!found_nxt) begin
              tgt_nxt = lru_idx_nxt;
            end
          end else begin
            st_nxt = S_FINISH;
          end
        end
      end
      S_PASS2: begin
        shift_en = 1'b1;
        cnt_nxt  = cnt_r + IDX_W'(1);
        if (cnt_r == tgt_r) begin
          head_mod.valid             = 1'b1;
          head_mod.pay.key           = key_r;
          head_mod.pay.user          = user_r;
          head_mod.pay.tag           = tag_r;
          head_mod.pay.created       = now_r;
          head_mod.pay.used_at       = now_r;
          res_status_nxt             = 1'b0;
          res_slot_nxt               = 6'(cnt_r);
          res_pay_nxt                = head_mod.pay;
          if (found_r) begin
            live_nxt = live_r + LIVE_W'(1);
          end
        end
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          st_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // State, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      ttl_r       <= 32'd3600;
      idle_r      <= 32'd900;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == stl_pkg::CFG_SESSION_TTL) begin
        ttl_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == stl_pkg::CFG_IDLE_TIMEOUT) begin
        idle_r <= cfg_wdata;
      end
    end
    tgt_r        <= tgt_nxt;
    lru_idx_r    <= lru_idx_nxt;
    lru_min_r    <= lru_min_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pay_r    <= res_pay_nxt;
    if (accept) begin
      func_r <= in_func;
      key_r  <= {in_key_w3, in_key_w2, in_key_w1, in_key_w0};
      user_r <= in_user_id;
      tag_r  <= in_session_tag;
      now_r  <= in_now;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_pay_r    <= res_pay_r;
      out_occ_r    <= 7'(live_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_user_id     = out_pay_r.user;
  assign out_session_tag = out_pay_r.tag;
  assign out_created     = out_pay_r.created;
  assign out_last_used   = out_pay_r.used_at;
  assign out_occupied    = out_occ_r;

`ifndef NO_ASSERTIONS
  // The live count never exceeds the table size.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_W'(SLOTS))
    else $error("live count above table size");

  // The ring is at its home position whenever no item is in work.
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE |-> cnt_r == '0)
    else $error("ring not at home position while idle");

  // A destroy-all result always reports an empty table.
  a_dall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && func_r == stl_pkg::FN_DESTROY_ALL |-> out_occ_r == 7'd0)
    else $error("destroy-all left live entries");

  // A result is loaded only from the finishing state.
  a_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> st_r == S_FINISH && st_nxt == S_IDLE)
    else $error("result loaded outside finish");
`endif

endmodule

[test/tb_session_table_lru_ttl_core.sv]
// ----------------------------------------------------------------------------
// tb_session_table_lru_ttl_core - self-checking bench for the session table
// Drives create, lookup, destroy, sweep, destroy-all and spare-code items
// through the valid/ready channels, predicts every result with a behavioral
// table copy and compares each result field by field in acceptance order.
// ----------------------------------------------------------------------------
module tb_session_table_lru_ttl_core;

  localparam int NSLOT = 64;
  localparam logic [39:0] NOW_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  // Idling modes of the two channels.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] k0, k1, k2, k3;
    logic [63:0] user;
    logic [63:0] tag;
    logic [39:0] now;
  } req_t;

  typedef struct {
    logic        status;
    logic [5:0]  slot;
    logic [63:0] user;
    logic [63:0] tag;
    logic [39:0] created;
    logic [39:0] used_at;
    logic [6:0]  occupied;
  } resp_t;

  typedef struct {
    req_t       req;
    bit         typed;
    logic       status;
    logic [5:0] slot;
    logic [6:0] occupied;
    bit         echo;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic [63:0] in_key_w0 = '0, in_key_w1 = '0, in_key_w2 = '0, in_key_w3 = '0;
  logic [63:0] in_user_id = '0, in_session_tag = '0;
  logic [39:0] in_now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [5:0] out_slot;
  logic [63:0] out_user_id, out_session_tag;
  logic [39:0] out_created, out_last_used;
  logic [6:0] out_occupied;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  session_table_lru_ttl_core DUT (.*);

  always #5 clk = ~clk;

  // Shadow copy of the table and its registers.
  bit          sh_valid [NSLOT];
  logic [63:0] sh_k0 [NSLOT], sh_k1 [NSLOT], sh_k2 [NSLOT], sh_k3 [NSLOT];
  logic [63:0] sh_user [NSLOT], sh_tag [NSLOT];
  logic [39:0] sh_created [NSLOT], sh_last [NSLOT];
  int          sh_live;
  logic [31:0] sh_ttl, sh_idle;

  resp_t expected_q [$];
  int    mismatches = 0;
  int    send_mode = IDLE_NONE;
  int    recv_mode = IDLE_NONE;
  int    hold_cycles = 0;
  logic [63:0] key_pool [12][4];
  logic [39:0] now_cur = '0;

  function automatic logic [39:0] age(logic [39:0] now, logic [39:0] then);
    return (now >= then) ? now - then : 40'd0;
  endfunction

  function automatic int find_session(req_t r);
    for (int i = 0; i < NSLOT; i++)
      if (sh_valid[i] && sh_k0[i] == r.k0 && sh_k1[i] == r.k1 &&
          sh_k2[i] == r.k2 && sh_k3[i] == r.k3)
        return i;
    return -1;
  endfunction

  // Apply one item to the shadow table and return the result it gives.
  function automatic resp_t apply_session_op(req_t r);
    resp_t o;
    int s;
    bit free_found;
    o = '{default: '0};
    case (r.func)
      stl_pkg::FN_CREATE: begin
        s = 0;
        free_found = 0;
        for (int i = 0; i < NSLOT; i++)
          if (!free_found && !sh_valid[i]) begin
            s = i;
            free_found = 1;
          end
        if (!free_found) begin
          // Table full: evict the oldest last-used, lowest index on ties.
          for (int i = 1; i < NSLOT; i++)
            if (sh_last[i] < sh_last[s]) s = i;
        end else begin
          sh_valid[s] = 1;
          sh_live++;
        end
        sh_k0[s] = r.k0; sh_k1[s] = r.k1; sh_k2[s] = r.k2; sh_k3[s] = r.k3;
        sh_user[s] = r.user; sh_tag[s] = r.tag;
        sh_created[s] = r.now; sh_last[s] = r.now;
        o.slot = s[5:0]; o.user = r.user; o.tag = r.tag;
        o.created = r.now; o.used_at = r.now;
      end
      stl_pkg::FN_LOOKUP: begin
        s = find_session(r);
        if (s < 0) begin
          o.status = 1'b1;
        end else if (age(r.now, sh_created[s]) > {8'd0, sh_ttl} ||
                     age(r.now, sh_last[s]) > {8'd0, sh_idle}) begin
          sh_valid[s] = 0;
          sh_live--;
          o.status = 1'b1;
        end else begin
          sh_last[s] = r.now;
          o.slot = s[5:0]; o.user = sh_user[s]; o.tag = sh_tag[s];
          o.created = sh_created[s]; o.used_at = sh_last[s];
        end
      end
      stl_pkg::FN_DESTROY: begin
        s = find_session(r);
        if (s >= 0) begin
          sh_valid[s] = 0;
          sh_live--;
        end
      end
      stl_pkg::FN_SWEEP: begin
        for (int i = 0; i < NSLOT; i++)
          if (sh_valid[i] && age(r.now, sh_created[i]) > {8'd0, sh_ttl}) begin
            sh_valid[i] = 0;
            sh_live--;
          end
      end
      stl_pkg::FN_DESTROY_ALL: begin
        for (int i = 0; i < NSLOT; i++) sh_valid[i] = 0;
        sh_live = 0;
      end
      default: ;
    endcase
    o.occupied = sh_live[6:0];
    return o;
  endfunction

  // Register write; only called while the block is idle.
  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == stl_pkg::CFG_SESSION_TTL) sh_ttl = data;
    else sh_idle = data;
  endtask

  // Offer one item at a falling edge and hold it until accepted. An
  // expectation, when given, replaces the predicted result. Valid is left
  // high after acceptance until idling or the drain lowers it.
  task automatic offer_item(req_t r, bit use_typed, resp_t typed_resp);
    resp_t p;
    int idle_pct;
    idle_pct = 0;
    if (send_mode == IDLE_SEND) idle_pct = 63;
    else if (send_mode == IDLE_BOTH) idle_pct = 11;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= r.func;
    in_key_w0 <= r.k0; in_key_w1 <= r.k1; in_key_w2 <= r.k2; in_key_w3 <= r.k3;
    in_user_id <= r.user; in_session_tag <= r.tag; in_now <= r.now;
    do @(posedge clk); while (!(in_valid && in_ready));
    p = apply_session_op(r);
    expected_q.push_back(use_typed ? typed_resp : p);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  function automatic req_t random_req(int create_pct);
    req_t r;
    int k;
    int d;
    d = $urandom_range(0, 99);
    if (d < create_pct) r.func = stl_pkg::FN_CREATE;
    else if (d < create_pct + (100 - create_pct) * 55 / 100) r.func = stl_pkg::FN_LOOKUP;
    else if (d < create_pct + (100 - create_pct) * 78 / 100) r.func = stl_pkg::FN_DESTROY;
    else if (d < create_pct + (100 - create_pct) * 92 / 100) r.func = stl_pkg::FN_SWEEP;
    else if (d < create_pct + (100 - create_pct) * 96 / 100)
      r.func = stl_pkg::FN_DESTROY_ALL;
    else r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    if ($urandom_range(0, 99) < 80) begin
      k = $urandom_range(0, 11);
      r.k0 = key_pool[k][0]; r.k1 = key_pool[k][1];
      r.k2 = key_pool[k][2]; r.k3 = key_pool[k][3];
    end else begin
      r.k0 = {$urandom, $urandom}; r.k1 = {$urandom, $urandom};
      r.k2 = {$urandom, $urandom}; r.k3 = {$urandom, $urandom};
    end
    r.user = {$urandom, $urandom};
    r.tag = {$urandom, $urandom};
    r.now = now_cur;
    return r;
  endfunction

  // One random phase: registers, idling, then items with time moving forward.
  task automatic run_phase(logic [31:0] ttl, logic [31:0] idle, int mode, int items,
                           int create_pct, int step_max);
    req_t r;
    resp_t none;
    none = '{default: '0};
    write_reg(stl_pkg::CFG_SESSION_TTL, ttl);
    write_reg(stl_pkg::CFG_IDLE_TIMEOUT, idle);
    send_mode = mode;
    recv_mode = mode;
    for (int n = 0; n < items; n++) begin
      // Mostly small steps, now and then a long jump in time.
      if ($urandom_range(0, 99) < 3) now_cur = now_cur + 40'($urandom);
      else now_cur = now_cur + 40'($urandom_range(0, step_max));
      r = random_req(create_pct);
      offer_item(r, 0, none);
    end
    wait_drained();
  endtask

  function automatic row_t mk_row(logic [2:0] f, logic [255:0] key, logic [63:0] user,
                                  logic [39:0] now, bit typed, logic st,
                                  logic [5:0] slot, logic [6:0] occ, bit echo);
    row_t w;
    w.req.func = f;
    {w.req.k3, w.req.k2, w.req.k1, w.req.k0} = key;
    w.req.user = user;
    w.req.tag = ~user;
    w.req.now = now;
    w.typed = typed; w.status = st; w.slot = slot; w.occupied = occ; w.echo = echo;
    return w;
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (recv_mode == IDLE_RECV) begin
      out_ready <= ($urandom_range(0, 99) >= 63);
    end else if (recv_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: slot %0d occupied %0d",
                                       out_slot, out_occupied);
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status || out_slot !== e.slot || out_user_id !== e.user ||
            out_session_tag !== e.tag || out_created !== e.created ||
            out_last_used !== e.used_at || out_occupied !== e.occupied) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: st %b slot %0d user %h tag %h cr %h lu %h occ %0d",
                     e.status, e.slot, e.user, e.tag, e.created, e.used_at, e.occupied);
            $display("         got: st %b slot %0d user %h tag %h cr %h lu %h occ %0d",
                     out_status, out_slot, out_user_id, out_session_tag, out_created,
                     out_last_used, out_occupied);
          end
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t rows [$];
    resp_t t;
    logic [255:0] ka, kb, kc;
    ka = '1;
    kb = '0;
    kc = {4{64'h5A5A_A5A5_0F0F_F0F0}};
    sh_ttl = 32'd3600;
    sh_idle = 32'd900;
    sh_live = 0;
    for (int i = 0; i < NSLOT; i++) sh_valid[i] = 0;
    for (int k = 0; k < 12; k++)
      for (int w = 0; w < 4; w++) key_pool[k][w] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values.
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, ka, 64'd0, 40'd0, 1, 1'b1, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_DESTROY, ka, 64'd0, 40'd0, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_SWEEP, kb, 64'd0, 40'd0, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(FN_SPARE_LO, ka, 64'd0, 40'd0, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(FN_SPARE_HI, kb, 64'd0, 40'd0, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(FN_SPARE_MID, kc, 64'd0, 40'd0, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_CREATE, ka, '1, 40'd0, 1, 1'b0, 6'd0, 7'd1, 1));
    rows.push_back(mk_row(stl_pkg::FN_CREATE, kb, 64'd0, 40'd10, 1, 1'b0, 6'd1, 7'd2, 1));
    // A duplicate key is stored again in the next free slot.
    rows.push_back(mk_row(stl_pkg::FN_CREATE, ka, 64'h1234, 40'd20, 1, 1'b0, 6'd2, 7'd3,
                          1));
    // Idle time exactly at the limit still hits the lowest matching slot.
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, ka, 64'd0, 40'd900, 0, 1'b0, 6'd0, 7'd0, 0));
    // One past the idle limit: the entry is dropped and a miss reported.
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, kb, 64'd0, 40'd911, 1, 1'b1, 6'd0, 7'd2, 0));
    rows.push_back(mk_row(stl_pkg::FN_DESTROY, ka, 64'd0, 40'd911, 1, 1'b0, 6'd0, 7'd1, 0));
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, ka, 64'd0, 40'd911, 0, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, kc, 64'd0, 40'd911, 1, 1'b1, 6'd0, 7'd1, 0));
    // Sweep exactly at the lifetime keeps the entry, one later clears it.
    rows.push_back(mk_row(stl_pkg::FN_SWEEP, kb, 64'd0, 40'd3620, 1, 1'b0, 6'd0, 7'd1, 0));
    rows.push_back(mk_row(stl_pkg::FN_SWEEP, kb, 64'd0, 40'd3621, 1, 1'b0, 6'd0, 7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_CREATE, kc, 64'hDEAD_BEEF, 40'd3621, 1, 1'b0, 6'd0,
                          7'd1, 1));
    rows.push_back(mk_row(stl_pkg::FN_CREATE, kb, 64'd7, 40'd3625, 1, 1'b0, 6'd1, 7'd2, 1));
    rows.push_back(mk_row(stl_pkg::FN_DESTROY_ALL, ka, 64'd0, 40'd3625, 1, 1'b0, 6'd0,
                          7'd0, 0));
    rows.push_back(mk_row(stl_pkg::FN_LOOKUP, kc, 64'd0, 40'd3625, 1, 1'b1, 6'd0, 7'd0, 0));
    foreach (rows[i]) begin
      t = '{default: '0};
      t.status = rows[i].status;
      t.slot = rows[i].slot;
      t.occupied = rows[i].occupied;
      if (rows[i].echo) begin
        t.user = rows[i].req.user; t.tag = rows[i].req.tag;
        t.created = rows[i].req.now; t.used_at = rows[i].req.now;
      end
      offer_item(rows[i].req, rows[i].typed, t);
    end
    wait_drained();
    now_cur = 40'd4000;

    // Random phases over several register settings and idling patterns.
    run_phase(32'd3600, 32'd900, IDLE_NONE, 150, 35, 40);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, IDLE_SEND, 200, 80, 5);
    run_phase(32'd0, 32'd0, IDLE_RECV, 150, 40, 2);
    run_phase(32'd300, 32'd60, IDLE_BOTH, 200, 40, 30);
    hold_cycles = 3000;
    run_phase(32'd5000, 32'd2000, IDLE_NONE, 150, 45, 50);
    run_phase(32'hFFFF_FFFF, 32'd100, IDLE_NONE, 100, 40, 60);
    // Time at its top value.
    now_cur = NOW_MAX;
    run_phase(32'd1, 32'hFFFF_FFFF, IDLE_BOTH, 40, 40, 0);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
